/* sv/erg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erg_pkg
// Shared types and constants for the euclidean rhythm generator.
// ----------------------------------------------------------------------------
package erg_pkg;

   localparam int SEQ_W = 64;
   localparam int LEN_W = 7;
   localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(SEQ_W);

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_TAIL,
      ST_DONE
   } state_type;

   // one level string: packed steps and its length
   typedef struct packed {
      logic [SEQ_W-1:0] bits;
      logic [LEN_W-1:0] len;
   } seq_type;

   // ones in the low n positions, all ones at full length
   function automatic logic [SEQ_W-1:0] low_mask(input logic [LEN_W-1:0] n);
      logic [SEQ_W-1:0] m;
      if (n >= FULL_LEN) begin
         m = '1;
      end else begin
         m = (SEQ_W'(1) << n) - SEQ_W'(1);
      end
      return m;
   endfunction

endpackage

/* sv/euclidean_rhythm_generator_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euclidean_rhythm_generator_unit
// Builds a Bjorklund euclidean rhythm mask from a pulse and a step count.
// ----------------------------------------------------------------------------
// One request word gives a pulse count and a step count; one response word
// returns the rhythm as a bit mask (bit i is step i) and its length. Step
// counts saturate at MAX_STEPS and pulses clamp to the step count. Zero
// steps, zero pulses and pulses equal to steps go straight to the done
// state. Any other pattern runs a remainder/quotient chain whose quotient
// is found by repeated subtraction, and every subtraction appends one copy
// of the previous level through a single shared shift-and-merge unit; each
// level ends with an exit check and a tail step. req_ready is low while a
// request is in work; a finished response waits in the output register, so
// the next request can be taken before the response is collected.
module euclidean_rhythm_generator_unit #(
   parameter int MAX_STEPS = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [erg_pkg::LEN_W-1:0]   req_pulse_count,
   input  logic [erg_pkg::LEN_W-1:0]   req_step_count,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [erg_pkg::SEQ_W-1:0]   rsp_pattern_bits,
   output logic [erg_pkg::LEN_W-1:0]   rsp_pattern_length
);
   import erg_pkg::*;

   localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_STEPS);

   state_type         state_ff, state_in;
   logic [LEN_W-1:0]  d_ff, d_in;
   logic [LEN_W-1:0]  r_ff, r_in;
   logic              final_ff, final_in;
   logic              tail_ff, tail_in;
   seq_type           prev_ff, prev_in;
   seq_type           prev2_ff, prev2_in;
   seq_type           cur_ff, cur_in;
   logic [LEN_W-1:0]  steps_ff, steps_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SEQ_W-1:0]  rsp_bits_ff, rsp_bits_in;
   logic [LEN_W-1:0]  rsp_len_ff, rsp_len_in;

   logic [LEN_W-1:0]  steps_c, pulses_c;
   logic              trivial_c;
   logic              accept_c, load_c;
   seq_type           src_c, app_c, cur_v;
   logic [LEN_W:0]    len_sum_c;

   // input clamping
   always_comb begin
      steps_c   = (req_step_count > MaxLen) ? MaxLen : req_step_count;
      pulses_c  = (req_pulse_count > steps_c) ? steps_c : req_pulse_count;
      trivial_c = (steps_c == '0) || (pulses_c == '0) || (pulses_c == steps_c);
   end

   // shared append unit: current string plus one copy of a stored level
   always_comb begin
      src_c       = (state_ff == ST_TAIL) ? prev2_ff : prev_ff;
      len_sum_c   = {1'b0, cur_ff.len} + {1'b0, src_c.len};
      app_c.len   = (len_sum_c > {1'b0, FULL_LEN}) ? FULL_LEN : len_sum_c[LEN_W-1:0];
      app_c.bits  = cur_ff.bits | (src_c.bits << cur_ff.len);
      cur_v       = tail_ff ? app_c : cur_ff;
   end

   assign accept_c = req_valid && req_ready;
   assign load_c   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = trivial_c ? ST_DONE : ST_DIV;
            end
         end
         ST_DIV: begin
            if (d_ff < r_ff) begin
               state_in = ST_TAIL;
            end
         end
         ST_TAIL: begin
            state_in = final_ff ? ST_DONE : ST_DIV;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and handshake outputs
   always_comb begin
      req_ready    = (state_ff == ST_IDLE);
      d_in         = d_ff;
      r_in         = r_ff;
      final_in     = final_ff;
      tail_in      = tail_ff;
      prev_in      = prev_ff;
      prev2_in     = prev2_ff;
      cur_in       = cur_ff;
      steps_in     = steps_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_bits_in  = rsp_bits_ff;
      rsp_len_in   = rsp_len_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept_c) begin
               steps_in = steps_c;
               if (trivial_c) begin
                  cur_in.bits = (pulses_c == '0) ? '0 : low_mask(steps_c);
                  cur_in.len  = steps_c;
               end else begin
                  d_in          = steps_c - pulses_c;
                  r_in          = pulses_c;
                  final_in      = 1'b0;
                  tail_in       = 1'b1;
                  prev2_in.bits = SEQ_W'(1);
                  prev2_in.len  = LEN_W'(1);
                  prev_in.bits  = '0;
                  prev_in.len   = LEN_W'(1);
                  cur_in        = '0;
               end
            end
         end
         ST_DIV: begin
            // one subtraction, one appended copy of the previous level
            if (d_ff >= r_ff) begin
               cur_in = app_c;
               d_in   = d_ff - r_ff;
            end
         end
         ST_TAIL: begin
            if (final_ff) begin
               cur_in = cur_v;
            end else begin
               prev2_in = prev_ff;
               prev_in  = cur_v;
               cur_in   = '0;
               d_in     = r_ff;
               if (d_ff <= LEN_W'(1)) begin
                  // last level repeats the divisor times, tail only on remainder one
                  final_in = 1'b1;
                  tail_in  = (d_ff != '0);
                  r_in     = LEN_W'(1);
               end else begin
                  r_in    = d_ff;
                  tail_in = 1'b1;
               end
            end
         end
         ST_DONE: begin
            if (load_c) begin
               rsp_valid_in = 1'b1;
               rsp_bits_in  = cur_ff.bits & low_mask(steps_ff);
               rsp_len_in   = steps_ff;
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      d_ff        <= d_in;
      r_ff        <= r_in;
      final_ff    <= final_in;
      tail_ff     <= tail_in;
      prev_ff     <= prev_in;
      prev2_ff    <= prev2_in;
      cur_ff      <= cur_in;
      steps_ff    <= steps_in;
      rsp_bits_ff <= rsp_bits_in;
      rsp_len_ff  <= rsp_len_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pattern_bits   = rsp_bits_ff;
   assign rsp_pattern_length = rsp_len_ff;

`ifndef ASSERT_OFF
   // the divisor is never zero while subtracting
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (r_ff != '0))
      else $error("zero divisor in subtract loop");

   // built string never runs past the mask width
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV || state_ff == ST_TAIL) |-> (cur_ff.len <= FULL_LEN))
      else $error("level string too long");

   // an accepted request always starts work
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept_c |=> (state_ff != ST_IDLE))
      else $error("request accepted but sequencer idle");

   // response length respects the step limit and no bits above it
   a_rsp_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_pattern_length <= MaxLen)
                     && ((rsp_pattern_bits >> rsp_pattern_length) == '0)))
      else $error("response bits beyond pattern length");
`endif

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the euclidean rhythm generator unit.
// ----------------------------------------------------------------------------
// Request words carry a pulse and a step count; each accepted request is run
// through a local Bjorklund builder and the expected rhythm word is queued.
// Every response word is compared field by field against the oldest queued
// rhythm. Directed corners come first, then a long random mix with random
// idling on both channels, a response hold-off that backs the unit up, and
// full drains between phases.
// ----------------------------------------------------------------------------
module tb;
   import erg_pkg::*;

   localparam int MAX_STEPS   = 64;
   localparam int CHAIN_N     = MAX_STEPS + 4;
   localparam int RAND_WORDS  = 800;
   localparam int LATENCY     = 2 * MAX_STEPS + 16;
   localparam int CYCLE_LIMIT = 600000;
   localparam int STALL_LEN   = 400;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [LEN_W-1:0] req_pulse_count = '0;
   logic [LEN_W-1:0] req_step_count = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [SEQ_W-1:0] rsp_pattern_bits;
   logic [LEN_W-1:0] rsp_pattern_length;

   // idle controls and bookkeeping
   logic    src_idle_en = 1'b0;
   logic    snk_idle_en = 1'b0;
   logic    rsp_stall = 1'b0;
   event    rsp_stall_start;
   seq_type pending_rhythms [$];
   int      error_count = 0;
   int      sent_words = 0;
   int      checked_words = 0;

   euclidean_rhythm_generator_unit #(
      .MAX_STEPS(MAX_STEPS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_pulse_count(req_pulse_count),
      .req_step_count(req_step_count),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_pattern_bits(rsp_pattern_bits),
      .rsp_pattern_length(rsp_pattern_length)
   );

   always #6 clock = ~clock;

   // ones in the low n steps
   function automatic logic [SEQ_W-1:0] span_mask(input int unsigned n);
      if (n >= SEQ_W) return '1;
      return (SEQ_W'(1) << n) - SEQ_W'(1);
   endfunction

   // bjorklund rhythm for one request word
   function automatic seq_type bjorklund_rhythm(input logic [LEN_W-1:0] pulse_in,
                                                input logic [LEN_W-1:0] step_in);
      int unsigned steps, pulses, divisor, depth, n;
      int unsigned cnt [0:CHAIN_N-1];
      int unsigned rem [0:CHAIN_N-1];
      logic [SEQ_W-1:0] lvl_bits [0:CHAIN_N+1];
      int unsigned lvl_len [0:CHAIN_N+1];
      seq_type r;
      steps = 32'(step_in);
      pulses = 32'(pulse_in);
      if (steps > MAX_STEPS) steps = MAX_STEPS;
      if (pulses > steps) pulses = steps;
      r.len = LEN_W'(steps);
      r.bits = '0;
      if (steps == 0 || pulses == 0) return r;
      if (pulses == steps) begin
         r.bits = span_mask(steps);
         return r;
      end
      // remainder/quotient chain
      divisor = steps - pulses;
      rem[0] = pulses;
      depth = 0;
      do begin
         cnt[depth] = divisor / rem[depth];
         rem[depth+1] = divisor % rem[depth];
         divisor = rem[depth];
         depth++;
      end while (rem[depth] > 1 && depth + 1 < CHAIN_N);
      cnt[depth] = divisor;
      // entry 0 is the "1" base, entry 1 the "0" base
      lvl_bits[0] = SEQ_W'(1);
      lvl_len[0] = 1;
      lvl_bits[1] = '0;
      lvl_len[1] = 1;
      for (int l = 0; l <= int'(depth); l++) begin
         lvl_bits[l+2] = '0;
         lvl_len[l+2] = 0;
         for (int k = 0; k < int'(cnt[l]) && lvl_len[l+2] < SEQ_W; k++) begin
            n = (lvl_len[l+1] < SEQ_W - lvl_len[l+2]) ? lvl_len[l+1]
                                                      : SEQ_W - lvl_len[l+2];
            lvl_bits[l+2] |= (lvl_bits[l+1] & span_mask(n)) << lvl_len[l+2];
            lvl_len[l+2] += n;
         end
         if (rem[l] != 0) begin
            n = (lvl_len[l] < SEQ_W - lvl_len[l+2]) ? lvl_len[l]
                                                    : SEQ_W - lvl_len[l+2];
            lvl_bits[l+2] |= (lvl_bits[l] & span_mask(n)) << lvl_len[l+2];
            lvl_len[l+2] += n;
         end
      end
      r.bits = lvl_bits[depth+2] & span_mask(steps);
      return r;
   endfunction

   // one line per mismatch
   task automatic report_error(input string msg);
      error_count++;
      $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   // response ready with random idling and hold-offs
   always @(negedge clock) begin
      if (rsp_stall) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !(snk_idle_en && $urandom_range(99) < 6);
      end
   end

   // long response hold-off, counted here
   always begin
      @(rsp_stall_start);
      rsp_stall = 1'b1;
      repeat (STALL_LEN) @(negedge clock);
      rsp_stall = 1'b0;
   end

   // compare each response word with the oldest queued rhythm
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         checked_words++;
         if (pending_rhythms.size() == 0) begin
            report_error($sformatf("unexpected word bits=%h len=%0d",
                                   rsp_pattern_bits, rsp_pattern_length));
         end else begin
            if (rsp_pattern_bits !== pending_rhythms[0].bits)
               report_error($sformatf("bits %h, want %h", rsp_pattern_bits,
                                      pending_rhythms[0].bits));
            if (rsp_pattern_length !== pending_rhythms[0].len)
               report_error($sformatf("length %0d, want %0d", rsp_pattern_length,
                                      pending_rhythms[0].len));
            void'(pending_rhythms.pop_front());
         end
      end
   end

   // watchdog
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("FAILURE");
      $finish;
   end

   // send one request word; returns at a falling edge with valid still high
   task automatic send_word(input logic [LEN_W-1:0] pulses, input logic [LEN_W-1:0] steps);
      while (src_idle_en && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pulse_count <= pulses;
      req_step_count <= steps;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_rhythms.insert(pending_rhythms.size(), bjorklund_rhythm(pulses, steps));
      sent_words++;
      @(negedge clock);
   endtask

   // stop sending until every queued rhythm has come back
   task automatic wait_all_collected();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_rhythms.size() != 0);
   endtask

   // corners: empty, saturation, clamping, all zeros, all ones, classic rhythms
   task automatic test_directed();
      send_word(0, 0);
      send_word(5, 0);
      send_word(127, 0);
      send_word(0, 64);
      send_word(64, 64);
      send_word(100, 64);
      send_word(1, 64);
      send_word(63, 64);
      send_word(32, 64);
      send_word(127, 127);
      send_word(5, 127);
      send_word(64, 100);
      send_word(0, 1);
      send_word(1, 1);
      send_word(1, 2);
      send_word(2, 5);
      send_word(3, 8);
      send_word(5, 8);
      send_word(7, 12);
      send_word(5, 13);
      send_word(13, 24);
      send_word(31, 63);
      wait_all_collected();
   endtask

   // random word mix; steps mostly in range, pulses mostly below steps
   task automatic test_random(input int words);
      int sel;
      int steps_eff;
      logic [LEN_W-1:0] steps;
      logic [LEN_W-1:0] pulses;
      for (int i = 0; i < words; i++) begin
         // quiet stretch first, then idling on both sides
         src_idle_en = (i >= 150);
         snk_idle_en = (i >= 150);
         sel = $urandom_range(99);
         if (sel < 5) steps = '0;
         else if (sel < 15) steps = LEN_W'($urandom_range(127, 65));
         else if (sel < 40) steps = LEN_W'($urandom_range(16, 1));
         else steps = LEN_W'($urandom_range(64, 1));
         steps_eff = (32'(steps) > MAX_STEPS) ? MAX_STEPS : 32'(steps);
         sel = $urandom_range(99);
         if (sel < 8) pulses = '0;
         else if (sel < 16) pulses = steps;
         else if (sel < 26) pulses = LEN_W'($urandom_range(127));
         else pulses = LEN_W'($urandom_range(steps_eff));
         send_word(pulses, steps);
      end
      wait_all_collected();
   endtask

   // hold responses off while requests keep coming, so the unit fills up
   task automatic test_backpressure();
      src_idle_en = 1'b0;
      -> rsp_stall_start;
      for (int i = 0; i < 8; i++)
         send_word(LEN_W'($urandom_range(63, 1)), 64);
      wait_all_collected();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_backpressure();
      test_random(RAND_WORDS);
      snk_idle_en = 1'b1;
      test_backpressure();

      repeat (LATENCY) @(posedge clock);
      if (pending_rhythms.size() != 0)
         report_error($sformatf("%0d rhythm words never came back",
                                pending_rhythms.size()));
      $display("sent %0d request words, checked %0d rhythm words", sent_words,
               checked_words);
      $display("covered empty, saturated, clamped, all-zero, all-one and random rhythms");
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* euclidean_rhythm_generator_unit.f */
sv/erg_pkg.sv
sv/euclidean_rhythm_generator_unit.sv
test/tb.sv
